[rtl/core/fpsqrt_pkg.sv]
// Shared constants, control-word types and the sequencer program for the square-root block.
package fpsqrt_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int MAX_ITERATIONS = 16;

  localparam int RADICAND_W = 32;
  localparam int ROOT_W     = 25;
  localparam int TOL_W      = 16;
  localparam int DVD_W      = RADICAND_W + FRAC_BITS;     // shifted radicand, also quotient
  localparam int ROUND_W    = $clog2(MAX_ITERATIONS + 1);
  localparam int DIV_STEPS  = DVD_W;
  localparam int DIVCNT_W   = $clog2(DIV_STEPS);
  localparam int PC_W       = 3;

  localparam logic [TOL_W-1:0]      TOL_RESET  = TOL_W'(66);
  localparam logic [RADICAND_W-1:0] FIX_ONE    = RADICAND_W'(1) << FRAC_BITS;
  localparam logic [RADICAND_W-1:0] ROOT_MAX   = RADICAND_W'((64'd1 << ROOT_W) - 64'd1);
  localparam logic [ROUND_W-1:0]    MAX_ROUNDS = ROUND_W'(MAX_ITERATIONS);
  localparam logic [DIVCNT_W-1:0]   LAST_DIV   = DIVCNT_W'(DIV_STEPS - 1);

  // Program step addresses
  localparam logic [PC_W-1:0] STEP_WAIT  = 3'd0;
  localparam logic [PC_W-1:0] STEP_TEST  = 3'd1;
  localparam logic [PC_W-1:0] STEP_CAP   = 3'd2;
  localparam logic [PC_W-1:0] STEP_MEAN  = 3'd3;
  localparam logic [PC_W-1:0] STEP_DIV   = 3'd4;
  localparam logic [PC_W-1:0] STEP_WRY   = 3'd5;
  localparam logic [PC_W-1:0] STEP_SPARE = 3'd6;
  localparam logic [PC_W-1:0] STEP_DONE  = 3'd7;

  typedef enum logic [2:0] {
    OP_NOP      = 3'd0,
    OP_LOAD     = 3'd1,
    OP_MARK_CAP = 3'd2,
    OP_MEAN     = 3'd3,
    OP_DIV_STEP = 3'd4,
    OP_WRITE_Y  = 3'd5,
    OP_PUBLISH  = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    CND_NEVER     = 3'd0,
    CND_ALWAYS    = 3'd1,
    CND_NO_ACCEPT = 3'd2,
    CND_CONVERGED = 3'd3,
    CND_CAP       = 3'd4,
    CND_DIV_MORE  = 3'd5,
    CND_OUT_BUSY  = 3'd6
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  // Microprogram: jump to target when the condition holds, else fall through.
  // The done step falls through to the wait step by wrap-around.
  function automatic ctrl_word_t sqrt_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    case (pc)
      STEP_WAIT: cw = '{op: OP_LOAD,     cond: CND_NO_ACCEPT, target: STEP_WAIT};
      STEP_TEST: cw = '{op: OP_NOP,      cond: CND_CONVERGED, target: STEP_DONE};
      STEP_CAP:  cw = '{op: OP_MARK_CAP, cond: CND_CAP,       target: STEP_DONE};
      STEP_MEAN: cw = '{op: OP_MEAN,     cond: CND_NEVER,     target: STEP_WAIT};
      STEP_DIV:  cw = '{op: OP_DIV_STEP, cond: CND_DIV_MORE,  target: STEP_DIV};
      STEP_WRY:  cw = '{op: OP_WRITE_Y,  cond: CND_ALWAYS,    target: STEP_TEST};
      STEP_DONE: cw = '{op: OP_PUBLISH,  cond: CND_OUT_BUSY,  target: STEP_DONE};
      default:   cw = '{op: OP_NOP,      cond: CND_ALWAYS,    target: STEP_WAIT};
    endcase
    return cw;
  endfunction

endpackage

[rtl/core/fixed_point_square_root_top.sv]
// Top level: microcoded Babylonian square root of an unsigned Q16.16 word.
// Steps: a load, then per round a test, a cap check, the mean, 48 divide steps and a
//   write-back; a closing test (plus the cap check when capped) and a publish step;
//   at most 16 rounds. Radicands 0 and 1.0 load, pass the first test and publish.
// One word at a time: the input stalls until publish, which waits out output stalls.
// Reset (rst_n, synchronous, active low): sequencer to wait, output empty, tolerance 66.
module fixed_point_square_root_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [fpsqrt_pkg::RADICAND_W-1:0] in_radicand,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [fpsqrt_pkg::ROOT_W-1:0]     out_root,
  output logic                             out_iteration_limit_hit,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fpsqrt_pkg::TOL_W-1:0]      cfg_tolerance
);
  import fpsqrt_pkg::*;

  // Sequencer
  logic [PC_W-1:0] pc_r, pc_nxt;
  ctrl_word_t      cw;
  logic            cond_true;

  // Datapath registers
  logic [RADICAND_W-1:0] n_r, n_nxt;
  logic [RADICAND_W-1:0] x_r, x_nxt;      // upper estimate
  logic [DVD_W-1:0]      y_r, y_nxt;      // lower estimate
  logic [DVD_W-1:0]      dvd_r, dvd_nxt;  // dividend shifting out, quotient shifting in
  logic [RADICAND_W-1:0] rem_r, rem_nxt;
  logic [DIVCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ROUND_W-1:0]    rounds_r, rounds_nxt;
  logic                  hit_r, hit_nxt;
  logic [TOL_W-1:0]      tol_r, tol_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [ROOT_W-1:0]     root_r, root_nxt;
  logic                  flag_r, flag_nxt;

  // Helpers
  logic                  accept;
  logic                  special;
  logic                  x_gt_y;
  logic [RADICAND_W-1:0] diff;
  logic                  converged;
  logic                  cap;
  logic                  out_busy;
  logic [RADICAND_W:0]   sum;
  logic [RADICAND_W-1:0] mean;
  logic [RADICAND_W:0]   rem_sh;
  logic [RADICAND_W:0]   rem_sub;
  logic                  ge;

  assign in_stall  = (pc_r != STEP_WAIT);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid               = out_valid_r;
  assign out_root                = root_r;
  assign out_iteration_limit_hit = flag_r;

  // Zero and exactly one start with x equal to y, so the first test ends at once.
  assign special   = (in_radicand == '0) || (in_radicand == FIX_ONE);

  // Stop when the bracket has closed or is within tolerance
  assign x_gt_y    = {{FRAC_BITS{1'b0}}, x_r} > y_r;
  assign diff      = x_r - y_r[RADICAND_W-1:0];
  assign converged = !(x_gt_y && (diff > {{(RADICAND_W-TOL_W){1'b0}}, tol_r}));
  assign cap       = (rounds_r == MAX_ROUNDS);
  assign out_busy  = out_valid_r && out_stall;

  // Mean: y is below x here, so the sum of the low words is exact
  assign sum  = {1'b0, x_r} + {1'b0, y_r[RADICAND_W-1:0]};
  assign mean = sum[RADICAND_W:1];

  // Restoring divide step; the partial remainder stays below x
  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, x_r};
  assign rem_sub = rem_sh - {1'b0, x_r};

  always_comb begin
    cw = sqrt_rom(pc_r);
    case (cw.cond)
      CND_NEVER:     cond_true = 1'b0;
      CND_ALWAYS:    cond_true = 1'b1;
      CND_NO_ACCEPT: cond_true = !accept;
      CND_CONVERGED: cond_true = converged;
      CND_CAP:       cond_true = cap;
      CND_DIV_MORE:  cond_true = (cnt_r != LAST_DIV);
      CND_OUT_BUSY:  cond_true = out_busy;
      default:       cond_true = 1'b0;
    endcase
    pc_nxt = cond_true ? cw.target : pc_r + 1'b1;
  end

  always_comb begin
    n_nxt         = n_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    rounds_nxt    = rounds_r;
    hit_nxt       = hit_r;
    root_nxt      = root_r;
    flag_nxt      = flag_r;
    tol_nxt       = tol_r;
    out_valid_nxt = out_valid_r;

    // Drop the result once the far side takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      tol_nxt = cfg_tolerance;
    end

    case (cw.op)
      OP_LOAD: begin
        // Capture the word and open the bracket [min(n,1), max(n,1)]
        if (accept) begin
          n_nxt      = in_radicand;
          hit_nxt    = 1'b0;
          rounds_nxt = '0;
          if (special) begin
            x_nxt = in_radicand;
            y_nxt = {{FRAC_BITS{1'b0}}, in_radicand};
          end else if (in_radicand > FIX_ONE) begin
            x_nxt = in_radicand;
            y_nxt = {{FRAC_BITS{1'b0}}, FIX_ONE};
          end else begin
            x_nxt = FIX_ONE;
            y_nxt = {{FRAC_BITS{1'b0}}, in_radicand};
          end
        end
      end
      OP_MARK_CAP: begin
        hit_nxt = cap;
      end
      OP_MEAN: begin
        // Move x to the mean, never zero, and arm the divider
        x_nxt      = (mean == '0) ? RADICAND_W'(1) : mean;
        rounds_nxt = rounds_r + 1'b1;
        dvd_nxt    = {n_r, {FRAC_BITS{1'b0}}};
        rem_nxt    = '0;
        cnt_nxt    = '0;
      end
      OP_DIV_STEP: begin
        rem_nxt = ge ? rem_sub[RADICAND_W-1:0] : rem_sh[RADICAND_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
      end
      OP_WRITE_Y: begin
        y_nxt = dvd_r;
      end
      OP_PUBLISH: begin
        // Hold until the output register is free, then load it with saturation
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          root_nxt      = (x_r > ROOT_MAX) ? ROOT_MAX[ROOT_W-1:0] : x_r[ROOT_W-1:0];
          flag_nxt      = hit_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_WAIT;
      out_valid_r <= 1'b0;
      tol_r       <= TOL_RESET;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      tol_r       <= tol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    rounds_r <= rounds_nxt;
    hit_r    <= hit_nxt;
    root_r   <= root_nxt;
    flag_r   <= flag_nxt;
  end

endmodule

[tb/fixed_point_square_root_top_test.sv]
// Self-checking testbench for the fixed-point Babylonian square-root block.
`timescale 1ns / 1ps

module fixed_point_square_root_top_test;
  import fpsqrt_pkg::*;

  localparam int    HALF_PERIOD    = 2;
  localparam int    RESET_CYCLES   = 10;
  localparam int    WORDS_PER_RUN  = 105;      // random words per tolerance setting
  localparam int    LONG_HOLD      = 2000;     // receiver hold-off, covers two full roots
  localparam int    SETTLE_CYCLES  = 8;
  localparam int    QUIET_CYCLES   = 900;      // about one worst-case root
  localparam int    N_DIRECTED     = 20;
  localparam int    N_TOL_SETTINGS = 6;
  localparam longint TIMEOUT_NS    = 64'd10_000_000;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic              limit_hit;
  } sqrt_result_t;

  // One directed row: the radicand, and whether the result is typed in here
  // (known = 1) or worked out by the predictor.
  typedef struct packed {
    logic [RADICAND_W-1:0] radicand;
    logic                  known;
    sqrt_result_t          result;
  } dir_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_RUNS
  } stall_mode_t;

  // Walked at the reset tolerance. Zero and exactly one come back unchanged.
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    {32'h0000_0000, 1'b1, 25'h000_0000, 1'b0},   // zero passes straight through
    {32'h0001_0000, 1'b1, 25'h001_0000, 1'b0},   // exactly 1.0 passes straight through
    {32'h0000_0001, 1'b0, 25'h0, 1'b0},          // smallest non-zero radicand
    {32'h0000_0002, 1'b0, 25'h0, 1'b0},
    {32'h0000_8000, 1'b0, 25'h0, 1'b0},          // 0.5, swapped bracket
    {32'h0000_FFFF, 1'b0, 25'h0, 1'b0},          // just below 1.0
    {32'h0001_0001, 1'b0, 25'h0, 1'b0},          // just above 1.0
    {32'h0001_8000, 1'b0, 25'h0, 1'b0},          // 1.5
    {32'h0001_FFFF, 1'b0, 25'h0, 1'b0},
    {32'h0002_0000, 1'b0, 25'h0, 1'b0},          // 2.0
    {32'h0004_0000, 1'b0, 25'h0, 1'b0},          // 4.0, exact root
    {32'h0009_0000, 1'b0, 25'h0, 1'b0},          // 9.0
    {32'h0064_0000, 1'b0, 25'h0, 1'b0},          // 100.0
    {32'h5555_5555, 1'b0, 25'h0, 1'b0},
    {32'hAAAA_AAAA, 1'b0, 25'h0, 1'b0},
    {32'h7FFF_FFFF, 1'b0, 25'h0, 1'b0},
    {32'h8000_0000, 1'b0, 25'h0, 1'b0},
    {32'hFFFF_0000, 1'b0, 25'h0, 1'b0},
    {32'hFFFF_FFFE, 1'b0, 25'h0, 1'b0},
    {32'hFFFF_FFFF, 1'b0, 25'h0, 1'b0}           // largest radicand
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [RADICAND_W-1:0] in_radicand;
  logic                  out_valid;
  logic                  out_stall;
  logic [ROOT_W-1:0]     out_root;
  logic                  out_iteration_limit_hit;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [TOL_W-1:0]      cfg_tolerance;

  // Predictor state and scoreboard
  logic [TOL_W-1:0] tolerance_now;
  sqrt_result_t     pending_roots [$];
  int               mismatches    = 0;
  int               words_sent    = 0;
  int               roots_checked = 0;
  int               cap_hits      = 0;
  int               tol_writes    = 0;
  int               burst_left    = 0;
  bit               hold_req      = 1'b0;
  bit               hold_served   = 1'b0;

  fixed_point_square_root_top dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_radicand             (in_radicand),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_root                (out_root),
    .out_iteration_limit_hit (out_iteration_limit_hit),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_tolerance           (cfg_tolerance)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Bracketed Babylonian iteration: upper estimate x, lower y = n/x. Every
  // halving and division truncates; the round count is capped and flagged.
  function automatic sqrt_result_t babylonian_root(input logic [RADICAND_W-1:0] n,
                                                   input logic [TOL_W-1:0] tol);
    logic [63:0]  unity;
    logic [63:0]  wide_n;
    logic [63:0]  dividend;
    logic [63:0]  x;
    logic [63:0]  y;
    int           rounds;
    sqrt_result_t r;
    unity       = 64'd1 << FRAC_BITS;
    wide_n      = 64'(n);
    dividend    = wide_n << FRAC_BITS;
    rounds      = 0;
    r.limit_hit = 1'b0;
    if (wide_n == 64'd0 || wide_n == unity) begin
      r.root = ROOT_W'(wide_n);
      return r;
    end
    // Start with the larger of n and 1.0 on top, so radicands below 1.0 converge
    if (wide_n > unity) begin
      x = wide_n;
      y = unity;
    end else begin
      x = unity;
      y = wide_n;
    end
    while (x > y && (x - y) > 64'(tol)) begin
      if (rounds >= MAX_ITERATIONS) begin
        r.limit_hit = 1'b1;
        break;
      end
      x = (x + y) >> 1;
      if (x == 64'd0) x = 64'd1;   // keep the division defined
      y = dividend / x;
      rounds++;
    end
    r.root = (x > 64'(ROOT_MAX)) ? ROOT_W'(ROOT_MAX) : ROOT_W'(x);
    return r;
  endfunction

  // Random radicand: full-range words most often, with extra weight on the regions
  // where the bracket behaves differently (below 1.0, around 1.0, the top end).
  function automatic logic [RADICAND_W-1:0] pick_radicand();
    logic [RADICAND_W-1:0] v;
    logic [15:0]           r;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4:          v = $urandom_range(0, 32'h0000_FFFF);
      5:          v = 32'h0000_FF00 + $urandom_range(0, 32'h200);
      6: begin
        r = 16'($urandom_range(1, 16'hFFFF));
        v = 32'(r) * 32'(r);
      end
      7:          v = $urandom | 32'hF000_0000;
      8:          v = $urandom_range(0, 32'h00FF_FFFF);
      default: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h0000_0000;
          1:       v = FIX_ONE;
          2:       v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0001;
        endcase
      end
    endcase
    return v;
  endfunction

  // Offer one word; the sender works in bursts with random gaps between them.
  // Hold valid and the payload until the word is taken, then log its result.
  task automatic offer_word(input logic [RADICAND_W-1:0] value, input logic known,
                            input sqrt_result_t known_result);
    int           gap;
    sqrt_result_t want;
    gap = 0;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      burst_left = $urandom_range(1, 8);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_radicand <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    words_sent++;
    want          = known ? known_result : babylonian_root(value, tolerance_now);
    pending_roots = {pending_roots, want};
  endtask

  // Stop offering and wait until every expected root has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    cfg_valid     <= 1'b1;
    cfg_tolerance <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tolerance_now = value;
    tol_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic check_root();
    sqrt_result_t want;
    if (pending_roots.size() == 0) begin
      $error("root %h (limit_hit %b) with nothing outstanding", out_root,
             out_iteration_limit_hit);
      mismatches++;
    end else begin
      want = pending_roots.pop_front();
      if (out_root !== want.root) begin
        $error("root: expected %h, got %h", want.root, out_root);
        mismatches++;
      end
      if (out_iteration_limit_hit !== want.limit_hit) begin
        $error("iteration_limit_hit: expected %b, got %b", want.limit_hit,
               out_iteration_limit_hit);
        mismatches++;
      end
      roots_checked++;
      if (out_iteration_limit_hit === 1'b1) cap_hits++;
    end
  endtask

  // Result side: check on the edge where a word is taken, then choose the
  // stall for the next cycle. The stall pattern switches between randomly
  // chosen modes, one mode being no stall at all. On request, hold off for a
  // long stretch so the block backs up into its input.
  initial begin : result_side
    stall_mode_t mode;
    int          mode_left;
    int          hold_left;
    int          run_left;
    int          phase_ctr;
    logic        stall_next;
    mode      = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    run_left  = 0;
    phase_ctr = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_root();
      phase_ctr++;
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = LONG_HOLD - 1;
        stall_next  = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(50, 600);
        end
        mode_left--;
        case (mode)
          STALL_RANDOM:   stall_next = ($urandom_range(0, 2) == 0);
          STALL_PERIODIC: stall_next = ((phase_ctr % 7) < 3);
          STALL_RUNS: begin
            if (run_left > 0) begin
              run_left--;
              stall_next = 1'b1;
            end else if ($urandom_range(0, 19) == 0) begin
              run_left   = $urandom_range(4, 30);
              stall_next = 1'b1;
            end else begin
              stall_next = 1'b0;
            end
          end
          default:        stall_next = 1'b0;
        endcase
      end
      out_stall <= stall_next;
    end
  end

  // Stimulus: reset, the directed table at the reset tolerance, then one random
  // run per tolerance setting, draining before every register write.
  initial begin : word_side
    logic [TOL_W-1:0] tol_plan [N_TOL_SETTINGS];
    sqrt_result_t     blank;
    blank         = '0;
    tolerance_now = TOL_RESET;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_radicand   <= '0;
    cfg_valid     <= 1'b0;
    cfg_tolerance <= '0;
    // One and the top of the register first, then zero tolerance (runs until the
    // bracket closes or the cap), then random settings and the reset value again.
    tol_plan[0] = 16'd1;
    tol_plan[1] = 16'hFFFF;
    tol_plan[2] = 16'd0;
    tol_plan[3] = TOL_W'($urandom_range(2, 16'hFFFE));
    tol_plan[4] = TOL_RESET;
    tol_plan[5] = TOL_W'($urandom_range(2, 600));
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_word(DIRECTED[i].radicand, DIRECTED[i].known, DIRECTED[i].result);
    end

    for (int p = 0; p < N_TOL_SETTINGS; p++) begin
      drain_results();
      write_tolerance(tol_plan[p]);
      // Ask for the long hold-off once, while words keep being offered
      if (p == 3) hold_req = 1'b1;
      for (int k = 0; k < WORDS_PER_RUN; k++) begin
        offer_word(pick_radicand(), 1'b0, blank);
      end
    end

    drain_results();
    repeat (QUIET_CYCLES) @(posedge clk);

    $display("%0d radicands sent (%0d directed) across %0d tolerance writes;",
             words_sent, N_DIRECTED, tol_writes);
    $display("%0d roots checked, %0d stopped at the iteration cap, %0d mismatches",
             roots_checked, cap_hits, mismatches);
    if (mismatches == 0 && pending_roots.size() == 0) begin
      $display("fixed_point_square_root_top_test: done, clean");
    end else begin
      $display("fixed_point_square_root_top_test: done, errors");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout with %0d roots outstanding", pending_roots.size());
    $display("fixed_point_square_root_top_test: done, errors");
    $finish;
  end

endmodule
